[src/indexed_ordered_list_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list block
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_TOP_ASSERT_SVH
`define INDEXED_ORDERED_LIST_TOP_ASSERT_SVH

// Same-cycle implication.
`define ORDL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ORDL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ordl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordl_pkg
// Types and constants shared by the ordered list block.
// ----------------------------------------------------------------------------
package ordl_pkg;

  localparam int ORDL_CAPACITY = 16;
  localparam int DATA_W        = 32;
  localparam int INDEX_W       = 8;
  localparam int ENTRIES_W     = 5;

  localparam logic [DATA_W-1:0] NOT_FOUND = '1;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_APPEND = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic                 ok;
    logic [DATA_W-1:0]    read_value;
    logic [ENTRIES_W-1:0] entries;
  } res_t;

endpackage

[src/ordl_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordl_mem
// Cell storage of the list: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ordl_mem
  import ordl_pkg::*;
#(
  parameter int DEPTH = ORDL_CAPACITY,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] cells [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= cells[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/ordl_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordl_ctrl
// Command sequencer: decodes a command and walks the cells one move at a time.
// ----------------------------------------------------------------------------
module ordl_ctrl
  import ordl_pkg::*;
#(
  parameter int CAPACITY = ORDL_CAPACITY,
  parameter int AW       = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cmd_t               in_cmd,
  input  logic [INDEX_W-1:0] in_index,
  input  logic [DATA_W-1:0]  in_value,
  output res_t               res,
  input  logic               res_take,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [DATA_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [AW-1:0]      mem_raddr,
  input  logic [DATA_W-1:0]  mem_rdata
);

  localparam int OW = $clog2(CAPACITY + 1);
  localparam int CW = (OW > INDEX_W) ? OW : INDEX_W;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic              ok_r, ok_nxt;
  logic [OW-1:0]     ptr_r, ptr_nxt;
  logic [OW-1:0]     occ_r, occ_nxt;

  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     occ_ext;
  logic              idx_hit;
  logic              not_full;
  logic [OW-1:0]     ptr_inc;
  logic [OW-1:0]     ptr_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
    rd_r  <= rd_nxt;
    ok_r  <= ok_nxt;
    ptr_r <= ptr_nxt;
  end

  // Separate pointer increment and decrement serve the two shift directions.
  assign idx_ext  = CW'(in_index);
  assign occ_ext  = CW'(occ_r);
  assign idx_hit  = idx_ext < occ_ext;
  assign not_full = occ_r < OW'(CAPACITY);
  assign ptr_inc  = ptr_r + 1'b1;
  assign ptr_dec  = ptr_r - 1'b1;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    rd_nxt    = rd_r;
    ok_nxt    = ok_r;
    ptr_nxt   = ptr_r;
    occ_nxt   = occ_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = AW'(ptr_r);
    mem_wdata = val_r;
    mem_re    = 1'b0;
    mem_raddr = AW'(ptr_r);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_cmd;
          val_nxt = in_value;
          ok_nxt  = 1'b0;
          rd_nxt  = '0;
          unique case (in_cmd)
            CMD_READ: begin
              if (idx_hit) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(in_index);
                state_nxt = ST_READ;
              end else begin
                rd_nxt    = NOT_FOUND;
                state_nxt = ST_DONE;
              end
            end
            CMD_INSERT: begin
              ptr_nxt   = occ_r;
              state_nxt = not_full ? ST_STEP : ST_DONE;
            end
            CMD_APPEND: begin
              if (not_full) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(occ_r);
                mem_wdata = in_value;
                occ_nxt   = occ_r + 1'b1;
                ok_nxt    = 1'b1;
              end
              state_nxt = ST_DONE;
            end
            CMD_REMOVE: begin
              ptr_nxt   = OW'(in_index);
              state_nxt = idx_hit ? ST_STEP : ST_DONE;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end

      ST_READ: begin
        rd_nxt    = mem_rdata;
        ok_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end

      // Insert walks from the back towards the front, remove from the
      // removed position towards the back; each move is a read then a write.
      ST_STEP: begin
        if (cmd_r == CMD_INSERT) begin
          if (ptr_r == '0) begin
            mem_we    = 1'b1;
            occ_nxt   = occ_r + 1'b1;
            ok_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(ptr_dec);
            state_nxt = ST_MOVE;
          end
        end else begin
          if (ptr_inc >= occ_r) begin
            occ_nxt   = occ_r - 1'b1;
            ok_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(ptr_inc);
            state_nxt = ST_MOVE;
          end
        end
      end

      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        ptr_nxt   = (cmd_r == CMD_INSERT) ? ptr_dec : ptr_inc;
        state_nxt = ST_STEP;
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [CW-1:0] occ_cnt;
  assign occ_cnt = CW'(occ_r);
  assign res     = {(state_r == ST_DONE), ok_r, rd_r, occ_cnt[ENTRIES_W-1:0]};

endmodule

[src/indexed_ordered_list_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_ordered_list_top
// Bounded ordered list of signed 32-bit values driven by a command stream.
// ----------------------------------------------------------------------------
// Each input item is one command (read at index, insert at front, append at
// back, remove at index) and gives exactly one result item with the value
// read, a success flag and the entry count after the command.
// Input: in_tuser carries the command, in_tdata the index and the value.
// Output: out_tdata carries the value read and the entry count, out_tuser ok.
// A read fetches the cell at the index; an append writes at the back at once;
// a failed command writes nothing; insert moves all N entries held back by one,
// remove moves the entries behind index I forward by one. The result reaches
// out_tvalid in the same cycle as the next command can be taken. Each cell move
// costs a memory read and a write through the single port pair of the store.
// The block takes one command at a time; in_tready is low while it works.
// A finished result waits in the output register while the next command is
// taken and worked on; if that result is still stalled when the next one is
// ready, the sequencer holds until out_tready frees the register.
// Reset empties the list at once, with no clearing pass; cell contents are
// left as they were and are never read until written again.
// ----------------------------------------------------------------------------
module indexed_ordered_list_top
  import ordl_pkg::*;
#(
  parameter int CAPACITY = ORDL_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // index [7:0], value [39:8]
  input  logic [1:0]  in_tuser,   // cmd [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_value [31:0], entries [36:32], zero fill
  output logic        out_tuser   // ok [0]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  res_t              res;
  logic              res_take;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  logic              out_valid_r;
  res_t              out_res_r;

  ordl_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (cmd_t'(in_tuser)),
    .in_index  (in_tdata[7:0]),
    .in_value  (in_tdata[39:8]),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ordl_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register is refilled as soon as it is empty or being drained.
  assign res_take = res.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.entries, out_res_r.read_value};
  assign out_tuser  = out_res_r.ok;

`include "indexed_ordered_list_top_assert.svh"

  `ORDL_ASSERT_IMP(a_ready_no_pending, in_tready, !res.valid, "ready with a pending result")
  `ORDL_ASSERT_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `ORDL_ASSERT_NXT(a_take_fills_out, res_take, out_tvalid, "taken result not presented")
  `ORDL_ASSERT_IMP(a_failed_read_value, res.valid && !res.ok && res.read_value != '0, res.read_value == NOT_FOUND, "bad value on failure")

endmodule
